@@ rtl/fdt_pkg.sv @@
// Package with types, codes and helpers for the structure token walker.
`default_nettype none

package fdt_pkg;

	// Default limits for the walk.
	localparam int DEPTH_LIMIT_DEF = 16;
	localparam int NODE_LIMIT_DEF  = 128;

	// Field widths of the channels.
	localparam int WORD_W  = 32;
	localparam int KIND_W  = 3;
	localparam int ERR_W   = 3;
	localparam int NODE_W  = 7;
	localparam int DEPTH_W = 5;
	localparam int IDX_W   = 30;
	localparam int MASK_W  = 3;

	// Configuration port geometry.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Structure block tokens.
	localparam logic [WORD_W-1:0] TOK_BEGIN    = 32'h0000_0001;
	localparam logic [WORD_W-1:0] TOK_END_NODE = 32'h0000_0002;
	localparam logic [WORD_W-1:0] TOK_PROP     = 32'h0000_0003;
	localparam logic [WORD_W-1:0] TOK_NOP      = 32'h0000_0004;
	localparam logic [WORD_W-1:0] TOK_END      = 32'h0000_0009;

	// Event mask bits.
	localparam logic [MASK_W-1:0] MASK_BEGIN = 3'h1;
	localparam logic [MASK_W-1:0] MASK_ENDN  = 3'h2;
	localparam logic [MASK_W-1:0] MASK_PROP  = 3'h4;
	localparam logic [MASK_W-1:0] MASK_RESET = 3'h7;

	// Register indexes.
	typedef enum logic [0:0] {
		REG_EVENT_MASK = 1'b0
	} reg_idx_t;

	// Event kinds.
	typedef enum logic [KIND_W-1:0] {
		EV_BEGIN    = 3'd0,
		EV_NAME     = 3'd1,
		EV_END_NODE = 3'd2,
		EV_PROP_HDR = 3'd3,
		EV_PROP_DAT = 3'd4,
		EV_END      = 3'd5,
		EV_ERROR    = 3'd6
	} kind_t;

	// Error codes.
	typedef enum logic [ERR_W-1:0] {
		ERR_NONE      = 3'd0,
		ERR_UNKNOWN   = 3'd1,
		ERR_OVERFLOW  = 3'd2,
		ERR_UNDERFLOW = 3'd3,
		ERR_NODES     = 3'd4
	} err_t;

	// Walk phase, one-hot.
	typedef enum logic [4:0] {
		PH_TOKEN = 5'b00001,
		PH_NAME  = 5'b00010,
		PH_PLEN  = 5'b00100,
		PH_POFF  = 5'b01000,
		PH_DATA  = 5'b10000
	} phase_t;

	// One result item as it leaves the walker core.
	typedef struct packed {
		kind_t             event_kind;
		err_t              error_code;
		logic [NODE_W-1:0]  node_number;
		logic [DEPTH_W-1:0] nesting_depth;
		logic [WORD_W-1:0]  property_length;
		logic [WORD_W-1:0]  name_offset;
		logic [WORD_W-1:0]  payload_word;
		logic [IDX_W-1:0]   payload_index;
		logic               payload_last;
	} event_t;

	// True when any byte of the word is zero.
	function automatic logic has_zero_byte(input logic [WORD_W-1:0] w);
		return (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
		       (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
	endfunction

endpackage

`default_nettype wire

@@ rtl/fdt_stream_if.sv @@
// Channel interfaces for structure words in and walk events out.
`default_nettype none

interface fdt_word_if import fdt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] tree_word;
	logic              first_word;

	modport source(output valid, tree_word, first_word, input ready);
	modport sink(input valid, tree_word, first_word, output ready);
endinterface

interface fdt_event_if import fdt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  event_kind;
	logic [ERR_W-1:0]   error_code;
	logic [NODE_W-1:0]  node_number;
	logic [DEPTH_W-1:0] nesting_depth;
	logic [WORD_W-1:0]  property_length;
	logic [WORD_W-1:0]  name_offset;
	logic [WORD_W-1:0]  payload_word;
	logic [IDX_W-1:0]   payload_index;
	logic               payload_last;

	modport source(output valid, event_kind, error_code, node_number, nesting_depth,
		property_length, name_offset, payload_word, payload_index, payload_last,
		input ready);
	modport sink(input valid, event_kind, error_code, node_number, nesting_depth,
		property_length, name_offset, payload_word, payload_index, payload_last,
		output ready);
endinterface

`default_nettype wire

@@ rtl/fdt_apb_regs.sv @@
// APB register file holding the event mask.
`default_nettype none

module fdt_apb_regs import fdt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output logic      [MASK_W-1:0] event_mask
);

	logic [MASK_W-1:0] mask_q;
	reg_idx_t          reg_idx;
	logic              idx_in_range;

	// Registers sit on word addresses; the top address bit picks the index.
	assign reg_idx      = reg_idx_t'(paddr[APB_AW-1]);
	assign idx_in_range = (reg_idx == REG_EVENT_MASK);
	assign pready       = 1'b1;
	assign event_mask   = mask_q;

	// Write on the access phase of a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (psel && penable && pwrite && pready && idx_in_range) begin
			mask_q <= pwdata[MASK_W-1:0];
		end
	end

	// Read back the mask; other addresses read as zero.
	always_comb begin
		prdata = '0;
		if (idx_in_range) begin
			prdata = {{(APB_DW-MASK_W){1'b0}}, mask_q};
		end
	end

endmodule

`default_nettype wire

@@ rtl/fdt_walk_core.sv @@
// Walker state and the single-pass token decode for one structure word.
`default_nettype none

module fdt_walk_core import fdt_pkg::*; #(
	parameter int DEPTH_LIMIT = DEPTH_LIMIT_DEF,
	parameter int NODE_LIMIT  = NODE_LIMIT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [WORD_W-1:0] tree_word,
	input  wire logic              first_word,
	input  wire logic [MASK_W-1:0] event_mask,
	output logic                   ev_hit,
	output event_t                 ev
);

	localparam int DW = $clog2(DEPTH_LIMIT + 1);
	localparam int NW = $clog2(NODE_LIMIT);
	localparam logic [DW-1:0] DEPTH_MAX = DW'(DEPTH_LIMIT);
	localparam logic [NW:0]   NODE_MAX  = (NW + 1)'(NODE_LIMIT);

	// Walk state.
	phase_t            phase_q;
	logic [DW-1:0]     depth_q;
	logic [NW-1:0]     node_q;
	logic              seen_q;
	logic [IDX_W-1:0]  remain_q;
	logic [WORD_W-1:0] len_q;
	logic [WORD_W-1:0] off_q;
	logic [IDX_W-1:0]  pos_q;
	logic              fin_q;

	// State after a possible restart by the first-word flag.
	phase_t            ph;
	logic [DW-1:0]     dep;
	logic [NW-1:0]     node;
	logic              seen;
	logic [IDX_W-1:0]  rem;
	logic [WORD_W-1:0] len;
	logic [WORD_W-1:0] off;
	logic [IDX_W-1:0]  pos;
	logic              fin;

	// Next state.
	phase_t            ph_n;
	logic [DW-1:0]     dep_n;
	logic [NW-1:0]     node_n;
	logic              seen_n;
	logic [IDX_W-1:0]  rem_n;
	logic [WORD_W-1:0] len_n;
	logic [WORD_W-1:0] off_n;
	logic [IDX_W-1:0]  pos_n;
	logic              fin_n;

	// Result pieces.
	kind_t             kind;
	err_t              err;
	logic              prop_f;
	logic              pre_pop;
	logic [WORD_W-1:0] word;
	logic [IDX_W-1:0]  idx;
	logic              last;
	logic [WORD_W-1:0] len_m1;
	logic [NW+NODE_W-1:0]  node_ext;
	logic [DW+DEPTH_W-1:0] depth_ext;

	assign len_m1 = len - 32'd1;

	// Decode one word against the current phase.
	always_comb begin
		ph   = first_word ? PH_TOKEN : phase_q;
		dep  = first_word ? '0 : depth_q;
		node = first_word ? '0 : node_q;
		seen = first_word ? 1'b0 : seen_q;
		rem  = first_word ? '0 : remain_q;
		len  = first_word ? '0 : len_q;
		off  = first_word ? '0 : off_q;
		pos  = first_word ? '0 : pos_q;
		fin  = first_word ? 1'b0 : fin_q;

		ph_n    = ph;
		dep_n   = dep;
		node_n  = node;
		seen_n  = seen;
		rem_n   = rem;
		len_n   = len;
		off_n   = off;
		pos_n   = pos;
		fin_n   = fin;
		ev_hit  = 1'b0;
		kind    = EV_BEGIN;
		err     = ERR_NONE;
		prop_f  = 1'b0;
		pre_pop = 1'b0;
		word    = '0;
		idx     = '0;
		last    = 1'b0;

		if (!fin) begin
			case (ph)
				PH_NAME: begin
					idx  = pos;
					word = tree_word;
					last = has_zero_byte(tree_word);
					if (last) begin
						ph_n = PH_TOKEN;
					end else begin
						pos_n = pos + 1'b1;
					end
					kind   = EV_NAME;
					ev_hit = |(event_mask & MASK_BEGIN);
				end
				PH_PLEN: begin
					len_n = tree_word;
					ph_n  = PH_POFF;
				end
				PH_POFF: begin
					off_n = tree_word;
					pos_n = '0;
					if (len == '0) begin
						ph_n = PH_TOKEN;
					end else begin
						rem_n = len_m1[WORD_W-1:2];
						ph_n  = PH_DATA;
					end
					kind   = EV_PROP_HDR;
					prop_f = 1'b1;
					ev_hit = |(event_mask & MASK_PROP);
				end
				PH_DATA: begin
					idx  = pos;
					word = tree_word;
					last = (rem == '0);
					if (last) begin
						ph_n = PH_TOKEN;
					end else begin
						rem_n = rem - 1'b1;
						pos_n = pos + 1'b1;
					end
					kind   = EV_PROP_DAT;
					prop_f = 1'b1;
					ev_hit = |(event_mask & MASK_PROP);
				end
				default: begin
					ph_n = PH_TOKEN;
					case (tree_word)
						TOK_NOP: begin
						end
						TOK_BEGIN: begin
							if (dep >= DEPTH_MAX) begin
								err = ERR_OVERFLOW;
							end else if (seen && ({1'b0, node} + 1'b1 >= NODE_MAX)) begin
								err = ERR_NODES;
							end else begin
								node_n = seen ? node + 1'b1 : '0;
								seen_n = 1'b1;
								dep_n  = dep + 1'b1;
								pos_n  = '0;
								ph_n   = PH_NAME;
								kind   = EV_BEGIN;
								ev_hit = |(event_mask & MASK_BEGIN);
							end
						end
						TOK_END_NODE: begin
							if (dep == '0) begin
								err = ERR_UNDERFLOW;
							end else begin
								dep_n   = dep - 1'b1;
								pre_pop = 1'b1;
								kind    = EV_END_NODE;
								ev_hit  = |(event_mask & MASK_ENDN);
							end
						end
						TOK_PROP: begin
							len_n = '0;
							off_n = '0;
							ph_n  = PH_PLEN;
						end
						TOK_END: begin
							fin_n  = 1'b1;
							kind   = EV_END;
							ev_hit = 1'b1;
						end
						default: begin
							err = ERR_UNKNOWN;
						end
					endcase
					// Any error finishes the walk and leaves the rest of the state.
					if (err != ERR_NONE) begin
						fin_n  = 1'b1;
						ph_n   = PH_TOKEN;
						kind   = EV_ERROR;
						ev_hit = 1'b1;
					end
				end
			endcase
		end
	end

	// Result fields; the end-node event shows the depth before the pop.
	assign node_ext  = (NW + NODE_W)'(node_n);
	assign depth_ext = (DW + DEPTH_W)'(pre_pop ? dep : dep_n);

	always_comb begin
		ev.event_kind      = kind;
		ev.error_code      = err;
		ev.node_number     = node_ext[NODE_W-1:0];
		ev.nesting_depth   = depth_ext[DEPTH_W-1:0];
		ev.property_length = prop_f ? len_n : '0;
		ev.name_offset     = prop_f ? off_n : '0;
		ev.payload_word    = word;
		ev.payload_index   = idx;
		ev.payload_last    = last;
	end

	// State advances once for each word that is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TOKEN;
			depth_q  <= '0;
			node_q   <= '0;
			seen_q   <= 1'b0;
			remain_q <= '0;
			len_q    <= '0;
			off_q    <= '0;
			pos_q    <= '0;
			fin_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= ph_n;
			depth_q  <= dep_n;
			node_q   <= node_n;
			seen_q   <= seen_n;
			remain_q <= rem_n;
			len_q    <= len_n;
			off_q    <= off_n;
			pos_q    <= pos_n;
			fin_q    <= fin_n;
		end
	end

endmodule

`default_nettype wire

@@ rtl/fdt_structure_token_walker.sv @@
// Top level of the structure token walker: input register, core and result register.
//
// The block walks the structure block of a flattened device tree, one
// big-endian 32-bit word per transfer on the words channel. A word with
// first_word set restarts the walk. Each word yields zero or one event on
// the events channel: begin node, name word, end node, property header,
// property data, end or error. After an end token or an error, words give
// no event until the next first_word.
// The event mask is written over the APB port at address 0. The user must write
// it only while the block is idle; the block itself does not enforce this. The
// mask resets to all events enabled. pready is always high. Throughput is one
// word per cycle while the receiver does not stall. Each taken word waits in the
// input register until the result register is empty or drained, then loads its event.
// The input register and result register together let a new word be taken
// while a finished event waits for the receiver. When the receiver stalls,
// both registers fill and words.ready drops until the event is taken.
// Reset clears the walk state, empties both registers and sets the mask to 7.
`default_nettype none

module fdt_structure_token_walker import fdt_pkg::*; #(
	parameter int DEPTH_LIMIT = DEPTH_LIMIT_DEF,
	parameter int NODE_LIMIT  = NODE_LIMIT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	fdt_word_if.sink               words,
	fdt_event_if.source            events
);

	logic [MASK_W-1:0] event_mask;
	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              first_s1;
	logic              advance;
	logic              step;
	logic              ev_hit;
	event_t            ev;
	logic              out_valid_q;
	event_t            out_q;

	// Configuration registers.
	fdt_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.event_mask(event_mask)
	);

	// Handshake: the result register moves when empty or being drained.
	assign advance     = !out_valid_q || events.ready;
	assign step        = valid_s1 && advance;
	assign words.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.ready) begin
			valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			word_s1  <= words.tree_word;
			first_s1 <= words.first_word;
		end
	end

	// Token decode and walk state.
	fdt_walk_core #(
		.DEPTH_LIMIT(DEPTH_LIMIT),
		.NODE_LIMIT (NODE_LIMIT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.tree_word (word_s1),
		.first_word(first_s1),
		.event_mask(event_mask),
		.ev_hit    (ev_hit),
		.ev        (ev)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && ev_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && ev_hit) begin
			out_q <= ev;
		end
	end

	assign events.valid           = out_valid_q;
	assign events.event_kind      = out_q.event_kind;
	assign events.error_code      = out_q.error_code;
	assign events.node_number     = out_q.node_number;
	assign events.nesting_depth   = out_q.nesting_depth;
	assign events.property_length = out_q.property_length;
	assign events.name_offset     = out_q.name_offset;
	assign events.payload_word    = out_q.payload_word;
	assign events.payload_index   = out_q.payload_index;
	assign events.payload_last    = out_q.payload_last;

	// An error code is given exactly on error events.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid |-> ((events.event_kind == EV_ERROR) ==
		(events.error_code != ERR_NONE)))
		else $error("error code does not match event kind");

	// Property fields stay zero outside property events.
	a_prop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(events.valid && events.event_kind != EV_PROP_HDR &&
		events.event_kind != EV_PROP_DAT) |->
		(events.property_length == '0 && events.name_offset == '0))
		else $error("property fields set outside a property event");

	// The last-word mark only appears on name or data words.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(events.valid && events.payload_last) |->
		(events.event_kind == EV_NAME || events.event_kind == EV_PROP_DAT))
		else $error("last mark on an event without payload");

	// A stalled result keeps the input side from taking a second word.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !events.ready && valid_s1) |-> !words.ready)
		else $error("input taken while both registers are full");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the structure token walker: directed table, random walks, mask sweeps.
`default_nettype none

module tb;
	import fdt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_ITEMS   = 70;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 4000;
	localparam logic [APB_AW-1:0] MASK_ADDR = APB_AW'(4 * REG_EVENT_MASK);

	// How a row of the directed table is checked.
	typedef enum int {
		ROW_PREDICT,
		ROW_NONE,
		ROW_EVENT
	} row_check_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              first;
		row_check_t        check;
		event_t            ev;
	} dir_row_t;

	localparam event_t NO_EV = '0;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	fdt_word_if  words_ch();
	fdt_event_if events_ch();

	fdt_structure_token_walker i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.words   (words_ch),
		.events  (events_ch)
	);

	// Walk state of the predictor.
	phase_t            wk_phase;
	int unsigned       wk_depth;
	int unsigned       wk_node;
	bit                wk_seen;
	bit                wk_done;
	logic [IDX_W-1:0]  wk_left;
	logic [IDX_W-1:0]  wk_pos;
	logic [WORD_W-1:0] wk_len;
	logic [WORD_W-1:0] wk_noff;
	logic [MASK_W-1:0] wk_mask;

	event_t walk_events_due[$];

	int n_fail;
	int n_words;
	int n_live;
	int n_events;
	int n_masks;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	int plan_send[4] = '{0, 74, 0, 29};
	int plan_recv[4] = '{0, 0, 74, 29};
	logic [MASK_W-1:0] plan_mask[8] = '{3'd0, 3'd7, 3'd5, 3'd2, 3'd1, 3'd4, 3'd3, 3'd6};

	// Directed walk under the reset mask: names, both property shapes, underflow,
	// words after the walk has finished, properties before any node, end and bad tokens.
	dir_row_t dir_rows [25] = '{
		'{TOK_BEGIN, 1'b1, ROW_EVENT,
			'{EV_BEGIN, ERR_NONE, 7'd0, 5'd1, 32'd0, 32'd0, 32'd0, 30'd0, 1'b0}},
		'{32'h6162_6364, 1'b0, ROW_EVENT,
			'{EV_NAME, ERR_NONE, 7'd0, 5'd1, 32'd0, 32'd0, 32'h6162_6364, 30'd0, 1'b0}},
		'{32'h6500_0000, 1'b0, ROW_PREDICT, NO_EV},
		'{TOK_PROP, 1'b0, ROW_NONE, NO_EV},
		'{32'h0000_0000, 1'b0, ROW_NONE, NO_EV},
		'{32'hFFFF_FFFF, 1'b0, ROW_EVENT,
			'{EV_PROP_HDR, ERR_NONE, 7'd0, 5'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 30'd0, 1'b0}},
		'{TOK_PROP, 1'b0, ROW_NONE, NO_EV},
		'{32'd5, 1'b0, ROW_NONE, NO_EV},
		'{32'h0000_0010, 1'b0, ROW_PREDICT, NO_EV},
		'{32'hFFFF_FFFF, 1'b0, ROW_PREDICT, NO_EV},
		'{32'h0000_0000, 1'b0, ROW_PREDICT, NO_EV},
		'{TOK_NOP, 1'b0, ROW_NONE, NO_EV},
		'{TOK_BEGIN, 1'b0, ROW_PREDICT, NO_EV},
		'{32'h0000_0000, 1'b0, ROW_PREDICT, NO_EV},
		'{TOK_END_NODE, 1'b0, ROW_PREDICT, NO_EV},
		'{TOK_END_NODE, 1'b0, ROW_PREDICT, NO_EV},
		'{TOK_END_NODE, 1'b0, ROW_EVENT,
			'{EV_ERROR, ERR_UNDERFLOW, 7'd1, 5'd0, 32'd0, 32'd0, 32'd0, 30'd0, 1'b0}},
		'{32'h1234_5678, 1'b0, ROW_NONE, NO_EV},
		'{TOK_PROP, 1'b1, ROW_NONE, NO_EV},
		'{32'd4, 1'b0, ROW_NONE, NO_EV},
		'{32'h0000_0000, 1'b0, ROW_PREDICT, NO_EV},
		'{32'hA5A5_A5A5, 1'b0, ROW_PREDICT, NO_EV},
		'{TOK_END, 1'b0, ROW_EVENT,
			'{EV_END, ERR_NONE, 7'd0, 5'd0, 32'd0, 32'd0, 32'd0, 30'd0, 1'b0}},
		'{32'hFFFF_FFFF, 1'b1, ROW_EVENT,
			'{EV_ERROR, ERR_UNKNOWN, 7'd0, 5'd0, 32'd0, 32'd0, 32'd0, 30'd0, 1'b0}},
		'{32'h0000_0000, 1'b1, ROW_EVENT,
			'{EV_ERROR, ERR_UNKNOWN, 7'd0, 5'd0, 32'd0, 32'd0, 32'd0, 30'd0, 1'b0}}
	};

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		n_fail++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Clears the walk as a restart word does.
	function automatic void restart_walk();
		wk_phase = PH_TOKEN;
		wk_depth = 0;
		wk_node  = 0;
		wk_seen  = 1'b0;
		wk_done  = 1'b0;
		wk_left  = '0;
		wk_len   = '0;
		wk_noff  = '0;
		wk_pos   = '0;
	endfunction

	function automatic event_t form_event(input kind_t k, input err_t e, input bit prop,
			input logic [WORD_W-1:0] w, input logic [IDX_W-1:0] idx, input bit last);
		event_t ev;
		ev.event_kind      = k;
		ev.error_code      = e;
		ev.node_number     = NODE_W'(wk_node);
		ev.nesting_depth   = DEPTH_W'(wk_depth);
		ev.property_length = prop ? wk_len : '0;
		ev.name_offset     = prop ? wk_noff : '0;
		ev.payload_word    = w;
		ev.payload_index   = idx;
		ev.payload_last    = last;
		return ev;
	endfunction

	// An error stops the walk and is always reported.
	function automatic bit halt_walk(output event_t ev, input err_t code);
		wk_done  = 1'b1;
		wk_phase = PH_TOKEN;
		ev = form_event(EV_ERROR, code, 1'b0, '0, '0, 1'b0);
		return 1'b1;
	endfunction

	// Advances the walk by one word; returns 1 when the word yields an event.
	function automatic bit step_walk(input logic [WORD_W-1:0] w, input logic f,
			output event_t ev);
		bit               last;
		logic [IDX_W-1:0] idx;
		ev = '0;
		if (f) begin
			restart_walk();
		end
		if (wk_done) begin
			return 1'b0;
		end
		case (wk_phase)
			PH_NAME: begin
				idx  = wk_pos;
				last = ~|w[31:24] | ~|w[23:16] | ~|w[15:8] | ~|w[7:0];
				if (last) begin
					wk_phase = PH_TOKEN;
				end else begin
					wk_pos = wk_pos + 1'b1;
				end
				ev = form_event(EV_NAME, ERR_NONE, 1'b0, w, idx, last);
				return (wk_mask & MASK_BEGIN) != '0;
			end
			PH_PLEN: begin
				wk_len   = w;
				wk_phase = PH_POFF;
				return 1'b0;
			end
			PH_POFF: begin
				wk_noff = w;
				wk_pos  = '0;
				if (wk_len == '0) begin
					wk_phase = PH_TOKEN;
				end else begin
					wk_left  = IDX_W'((wk_len - 32'd1) >> 2);
					wk_phase = PH_DATA;
				end
				ev = form_event(EV_PROP_HDR, ERR_NONE, 1'b1, '0, '0, 1'b0);
				return (wk_mask & MASK_PROP) != '0;
			end
			PH_DATA: begin
				idx  = wk_pos;
				last = (wk_left == '0);
				if (last) begin
					wk_phase = PH_TOKEN;
				end else begin
					wk_left = wk_left - 1'b1;
					wk_pos  = wk_pos + 1'b1;
				end
				ev = form_event(EV_PROP_DAT, ERR_NONE, 1'b1, w, idx, last);
				return (wk_mask & MASK_PROP) != '0;
			end
			default: begin
			end
		endcase

		// Token decode.
		wk_phase = PH_TOKEN;
		case (w)
			TOK_NOP: begin
				return 1'b0;
			end
			TOK_BEGIN: begin
				if (wk_depth >= DEPTH_LIMIT_DEF) begin
					return halt_walk(ev, ERR_OVERFLOW);
				end
				if (wk_seen) begin
					if (wk_node + 1 >= NODE_LIMIT_DEF) begin
						return halt_walk(ev, ERR_NODES);
					end
					wk_node++;
				end else begin
					wk_node = 0;
					wk_seen = 1'b1;
				end
				wk_depth++;
				wk_pos   = '0;
				wk_phase = PH_NAME;
				ev = form_event(EV_BEGIN, ERR_NONE, 1'b0, '0, '0, 1'b0);
				return (wk_mask & MASK_BEGIN) != '0;
			end
			TOK_END_NODE: begin
				if (wk_depth == 0) begin
					return halt_walk(ev, ERR_UNDERFLOW);
				end
				ev = form_event(EV_END_NODE, ERR_NONE, 1'b0, '0, '0, 1'b0);
				wk_depth--;
				return (wk_mask & MASK_ENDN) != '0;
			end
			TOK_PROP: begin
				wk_len   = '0;
				wk_noff  = '0;
				wk_phase = PH_PLEN;
				return 1'b0;
			end
			TOK_END: begin
				wk_done = 1'b1;
				ev = form_event(EV_END, ERR_NONE, 1'b0, '0, '0, 1'b0);
				return 1'b1;
			end
			default: begin
				return halt_walk(ev, ERR_UNKNOWN);
			end
		endcase
	endfunction

	// Offers one word, waits for its transfer and records what it should yield.
	task automatic send_word(input logic [WORD_W-1:0] w, input logic f,
			input row_check_t chk = ROW_PREDICT, input event_t typed = '0);
		int     gap;
		bit     hit;
		event_t ev;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			words_ch.valid     <= 1'b0;
			words_ch.tree_word <= $urandom;
			repeat (gap) @(posedge clk);
		end
		words_ch.valid      <= 1'b1;
		words_ch.tree_word  <= w;
		words_ch.first_word <= f;
		do @(posedge clk); while (!words_ch.ready);
		n_words++;
		if (f || !wk_done) begin
			n_live++;
		end
		hit = step_walk(w, f, ev);
		case (chk)
			ROW_PREDICT: begin
				if (hit) begin
					walk_events_due.push_back(ev);
				end
			end
			ROW_EVENT: begin
				walk_events_due.push_back(typed);
			end
			default: begin
			end
		endcase
	endtask

	// Holds the sender off until every expected event has been taken.
	task automatic wait_for_events(input int settle);
		words_ch.valid <= 1'b0;
		do @(posedge clk); while (walk_events_due.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= MASK_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_mask_reg(input logic [MASK_W-1:0] want);
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, '0, rd);
		if (rd[MASK_W-1:0] !== want) begin
			report_mismatch($sformatf("event_mask reads %0h, want %0h", rd[MASK_W-1:0], want));
		end
	endtask

	task automatic set_event_mask(input logic [MASK_W-1:0] v);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, APB_DW'(v), rd);
		wk_mask = v;
		n_masks++;
		check_mask_reg(v);
	endtask

	// Word with no zero byte, so a name keeps going.
	function automatic logic [WORD_W-1:0] plain_word();
		return {8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
			8'($urandom_range(255, 1)), 8'($urandom_range(255, 1))};
	endfunction

	task automatic send_name();
		logic [WORD_W-1:0] w;
		int                pos;
		repeat ($urandom_range(2)) send_word(plain_word(), 1'b0);
		w   = $urandom;
		pos = $urandom_range(3);
		w[8*pos +: 8] = 8'h00;
		send_word(w, 1'b0);
	endtask

	task automatic send_prop(input logic f);
		int r;
		int len;
		r = $urandom_range(99);
		len = (r < 15) ? 0 : (r < 85) ? $urandom_range(12, 1) : $urandom_range(64, 13);
		send_word(TOK_PROP, f);
		send_word(WORD_W'(len), 1'b0);
		send_word($urandom, 1'b0);
		repeat ((len + 3) / 4) send_word($urandom, 1'b0);
	endtask

	// One walk: mostly a well-formed tree with random content, sometimes broken off.
	task automatic gen_walk(input int span);
		int depth;
		int r;
		depth = 0;
		if ($urandom_range(9) < 2) begin
			send_prop(1'b1);
		end else begin
			send_word(TOK_BEGIN, 1'b1);
			send_name();
			depth = 1;
		end
		repeat (span) begin
			r = $urandom_range(99);
			if (r < 4) begin
				// Broken sequence; the next walk restarts.
				case ($urandom_range(4))
					0: send_word($urandom_range(1) ? $urandom : $urandom_range(15, 5), 1'b0);
					1: repeat (depth + 1) send_word(TOK_END_NODE, 1'b0);
					2: begin
						send_word(TOK_PROP, 1'b0);
						send_word($urandom | 32'h8000_0000, 1'b0);
						send_word($urandom, 1'b0);
						repeat ($urandom_range(4, 1)) send_word($urandom, 1'b0);
					end
					3: begin
						send_word(TOK_BEGIN, 1'b0);
						send_word(plain_word(), 1'b0);
					end
					default: send_word(TOK_END, 1'b0);
				endcase
				return;
			end else if (r < 28 && depth < DEPTH_LIMIT_DEF) begin
				send_word(TOK_BEGIN, 1'b0);
				send_name();
				depth++;
			end else if (r < 50 && depth > 0) begin
				send_word(TOK_END_NODE, 1'b0);
				depth--;
			end else if (r < 55) begin
				send_word(TOK_NOP, 1'b0);
			end else begin
				send_prop(1'b0);
			end
		end
		repeat (depth) send_word(TOK_END_NODE, 1'b0);
		send_word(TOK_END, 1'b0);
		// Words after the end are dropped.
		repeat ($urandom_range(2)) send_word($urandom, 1'b0);
	endtask

	// Event receiver: random stalls and a field-by-field check of each transfer.
	initial begin
		event_t got;
		event_t want;
		events_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (events_ch.valid && events_ch.ready) begin
				got = '{kind_t'(events_ch.event_kind), err_t'(events_ch.error_code),
					events_ch.node_number, events_ch.nesting_depth, events_ch.property_length,
					events_ch.name_offset, events_ch.payload_word, events_ch.payload_index,
					events_ch.payload_last};
				n_events++;
				if (walk_events_due.size() == 0) begin
					report_mismatch($sformatf("event %0d kind %0d with none expected",
						n_events, got.event_kind));
				end else begin
					want = walk_events_due.pop_front();
					if (got.event_kind !== want.event_kind)
						report_mismatch($sformatf("event %0d event_kind %0d, want %0d",
							n_events, got.event_kind, want.event_kind));
					if (got.error_code !== want.error_code)
						report_mismatch($sformatf("event %0d error_code %0d, want %0d",
							n_events, got.error_code, want.error_code));
					if (got.node_number !== want.node_number)
						report_mismatch($sformatf("event %0d node_number %0d, want %0d",
							n_events, got.node_number, want.node_number));
					if (got.nesting_depth !== want.nesting_depth)
						report_mismatch($sformatf("event %0d nesting_depth %0d, want %0d",
							n_events, got.nesting_depth, want.nesting_depth));
					if (got.property_length !== want.property_length)
						report_mismatch($sformatf("event %0d property_length %0h, want %0h",
							n_events, got.property_length, want.property_length));
					if (got.name_offset !== want.name_offset)
						report_mismatch($sformatf("event %0d name_offset %0h, want %0h",
							n_events, got.name_offset, want.name_offset));
					if (got.payload_word !== want.payload_word)
						report_mismatch($sformatf("event %0d payload_word %0h, want %0h",
							n_events, got.payload_word, want.payload_word));
					if (got.payload_index !== want.payload_index)
						report_mismatch($sformatf("event %0d payload_index %0d, want %0d",
							n_events, got.payload_index, want.payload_index));
					if (got.payload_last !== want.payload_last)
						report_mismatch($sformatf("event %0d payload_last %0d, want %0d",
							n_events, got.payload_last, want.payload_last));
				end
			end
			events_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((words_ch.valid && words_ch.ready) || (events_ch.valid && events_ch.ready) ||
					psel) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("Watchdog expired after %0d quiet cycles", QUIET_LIMIT);
		$display("FAIL fdt_structure_token_walker");
		$finish;
	end

	// Main sequence.
	initial begin
		int  start;
		bit  paused;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		words_ch.valid      = 1'b0;
		words_ch.tree_word  = '0;
		words_ch.first_word = 1'b0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		n_fail   = 0;
		n_words  = 0;
		n_live   = 0;
		n_events = 0;
		n_masks  = 0;
		wk_mask  = MASK_RESET;
		restart_walk();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		check_mask_reg(MASK_RESET);

		// Directed table under the reset mask.
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].word, dir_rows[i].first, dir_rows[i].check, dir_rows[i].ev);
		end

		// Random walks under each mask and idle profile.
		for (int ph = 0; ph < 8; ph++) begin
			wait_for_events(SETTLE_CYCLES);
			set_event_mask(plan_mask[ph]);
			send_idle_pct  = plan_send[ph % 4];
			recv_stall_pct = plan_recv[ph % 4];
			start  = n_live;
			paused = 1'b0;
			if (ph == 1 || ph == 5) begin
				// Nest until the depth limit trips.
				send_word(TOK_BEGIN, 1'b1);
				send_name();
				repeat (DEPTH_LIMIT_DEF) begin
					send_word(TOK_BEGIN, 1'b0);
					send_name();
				end
			end
			if (ph == 3) begin
				// Sibling nodes until the node limit trips.
				send_word(TOK_BEGIN, 1'b1);
				send_name();
				repeat (NODE_LIMIT_DEF) begin
					send_word(TOK_BEGIN, 1'b0);
					send_name();
					send_word(TOK_END_NODE, 1'b0);
				end
			end
			while (n_live - start < PHASE_ITEMS) begin
				gen_walk($urandom_range(40, 4));
				if (!paused && n_live - start >= PHASE_ITEMS / 2) begin
					wait_for_events(0);
					paused = 1'b1;
				end
			end
		end
		wait_for_events(SETTLE_CYCLES);
		repeat (8) @(posedge clk);

		$display("Run covered %0d words (%0d walked) and %0d checked events", n_words, n_live,
			n_events);
		$display("over %0d event mask settings and four idle profiles, %0d mismatches.", n_masks,
			n_fail);
		if (n_fail == 0) begin
			$display("PASS fdt_structure_token_walker");
		end else begin
			$display("FAIL fdt_structure_token_walker");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/fdt_pkg.sv
rtl/fdt_stream_if.sv
rtl/fdt_apb_regs.sv
rtl/fdt_walk_core.sv
rtl/fdt_structure_token_walker.sv
bench/tb.sv
